[rtl/ccbrd_pkg.sv]
// Shared types and constants of the CPU bus register decoder.
// No dependencies; imported by the main store, register file, top level and testbench.
package ccbrd_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_WORD  = 2'd2
	} cmd_t;

	// Video register offsets within the folded window
	localparam logic [2:0] OFF_CTRL    = 3'd0;
	localparam logic [2:0] OFF_MASK    = 3'd1;
	localparam logic [2:0] OFF_STATUS  = 3'd2;
	localparam logic [2:0] OFF_OAMADDR = 3'd3;
	localparam logic [2:0] OFF_OAMDATA = 3'd4;
	localparam logic [2:0] OFF_SCROLL  = 3'd5;
	localparam logic [2:0] OFF_ADDR    = 3'd6;
	localparam logic [2:0] OFF_DATA    = 3'd7;

	localparam logic [15:0] REG_FIRST   = 16'h2000;
	localparam logic [15:0] REG_LAST    = 16'h3FFF;
	localparam logic [15:0] REG_FOLD    = 16'h0007;
	localparam logic [15:0] CTRL_WARMUP = 16'd29658;
	localparam logic [15:0] VADDR_MASK  = 16'h3FFF;
	localparam logic [15:0] STRIDE_ROW  = 16'd32;
	localparam logic [15:0] STRIDE_ONE  = 16'd1;
	localparam logic [7:0]  VBLANK_BIT  = 8'h80;
	localparam logic [7:0]  PAD_OPEN    = 8'h40;
	localparam int          CTRL_INC_BIT = 2;

	// Where the read byte of a beat comes from once it reaches the result stage
	typedef enum logic [1:0] {
		SRC_REG,
		SRC_SPRITE,
		SRC_MAIN,
		SRC_WORD
	} src_t;

	typedef struct packed {
		logic        fire;
		logic [1:0]  cmd;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic        ghost;
		logic [7:0]  buttons;
		logic [15:0] cycles;
	} req_t;

	typedef struct packed {
		src_t        src;
		logic [7:0]  rdata;
		logic        vram_valid;
		logic [15:0] vram_addr;
		logic [7:0]  vram_byte;
	} rsp_t;

	typedef struct packed {
		logic        rd;
		logic        we;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} macc_t;

endpackage

[rtl/ccbrd_access_if.sv]
// Access channel: one CPU bus access per beat.
// No dependencies.
interface ccbrd_access_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        ghost;
	logic [7:0]  button_state;
	logic [15:0] video_cycles;

	modport source (output valid, command, address, write_data, ghost, button_state,
		video_cycles, input ready);
	modport sink (input valid, command, address, write_data, ghost, button_state,
		video_cycles, output ready);
endinterface

[rtl/ccbrd_result_if.sv]
// Result channel: one result per access beat.
// No dependencies.
interface ccbrd_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        vram_write_valid;
	logic [15:0] vram_write_address;
	logic [7:0]  vram_write_byte;

	modport source (output valid, read_data, vram_write_valid, vram_write_address,
		vram_write_byte, input ready);
	modport sink (input valid, read_data, vram_write_valid, vram_write_address,
		vram_write_byte, output ready);
endinterface

[rtl/ccbrd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ccbrd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

[rtl/ccbrd_mstore.sv]
// Main store, split into even and odd byte banks so a word read fetches both bytes at once.
// Depends on ccbrd_pkg and ccbrd_ram.
module ccbrd_mstore
	import ccbrd_pkg::*;
(
	input  logic       clk,
	input  macc_t      acc,
	output logic [7:0] lo,
	output logic [7:0] hi
);
	localparam int BANK_DEPTH = 32768;

	logic [15:0] addr_p1;
	logic [7:0]  even_rdata;
	logic [7:0]  odd_rdata;
	logic        a0_q;

	// even bank serves addr or addr+1, whichever is even; odd bank likewise
	assign addr_p1 = acc.addr + 16'd1;

	ccbrd_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even (
		.clk   (clk),
		.we    (acc.we & ~acc.addr[0]),
		.waddr (acc.addr[15:1]),
		.wdata (acc.wdata),
		.re    (acc.rd),
		.raddr (addr_p1[15:1]),
		.rdata (even_rdata)
	);

	ccbrd_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd (
		.clk   (clk),
		.we    (acc.we & acc.addr[0]),
		.waddr (acc.addr[15:1]),
		.wdata (acc.wdata),
		.re    (acc.rd),
		.raddr (acc.addr[15:1]),
		.rdata (odd_rdata)
	);

	always_ff @(posedge clk) begin
		if (acc.rd)
			a0_q <= acc.addr[0];
	end

	assign lo = a0_q ? odd_rdata : even_rdata;
	assign hi = a0_q ? even_rdata : odd_rdata;
endmodule

[rtl/ccbrd_regs.sv]
// Address translation, video register file, pad shifter and sprite store.
// Depends on ccbrd_pkg and ccbrd_ram.
module ccbrd_regs
	import ccbrd_pkg::*;
#(
	parameter int ROM_BASE      = 32768,
	parameter int ROM_BANK_SIZE = 16384,
	parameter int PAD_PORT_ADDR = 16406
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  req_t       req,
	output rsp_t       rsp,
	output macc_t      macc,
	output logic [7:0] spr_rdata
);
	localparam logic [16:0] BANK_TOP  = 17'(ROM_BASE + ROM_BANK_SIZE);
	localparam logic [15:0] BANK_SIZE = 16'(ROM_BANK_SIZE);
	localparam logic [15:0] PAD_ADDR  = 16'(PAD_PORT_ADDR);

	logic        mirror_q;
	logic [7:0]  ctrl_q, ctrl_d;
	logic [7:0]  mask_q, mask_d;
	logic [7:0]  status_q, status_d;
	logic [7:0]  oam_addr_q, oam_addr_d;
	logic [15:0] scroll_q, scroll_d;
	logic [15:0] vaddr_q, vaddr_d;
	logic [7:0]  vdata_q, vdata_d;
	logic        scr_rph_q, scr_rph_d;
	logic        scr_wph_q, scr_wph_d;
	logic        adr_rph_q, adr_rph_d;
	logic        adr_wph_q, adr_wph_d;
	logic [7:0]  pad_q, pad_d;

	logic        in_regs;
	logic        mirrored;
	logic [15:0] a;
	logic        is_pad;
	logic [2:0]  off;
	logic        scr_ph;
	logic        adr_ph;
	logic [15:0] stride;
	logic        spr_we;
	logic        spr_re;

	assign in_regs  = (req.addr >= REG_FIRST) && (req.addr <= REG_LAST);
	assign mirrored = mirror_q && ({1'b0, req.addr} >= BANK_TOP);
	assign a = in_regs ? (REG_FIRST | (req.addr & REG_FOLD)) :
		mirrored ? (req.addr - BANK_SIZE) : req.addr;
	assign is_pad = (a == PAD_ADDR);
	assign off    = a[2:0];
	assign scr_ph = ~scr_rph_q;
	assign adr_ph = ~adr_rph_q;
	assign stride = ctrl_q[CTRL_INC_BIT] ? STRIDE_ROW : STRIDE_ONE;

	always_comb begin
		ctrl_d     = ctrl_q;
		mask_d     = mask_q;
		status_d   = status_q;
		oam_addr_d = oam_addr_q;
		scroll_d   = scroll_q;
		vaddr_d    = vaddr_q;
		vdata_d    = vdata_q;
		scr_rph_d  = scr_rph_q;
		scr_wph_d  = scr_wph_q;
		adr_rph_d  = adr_rph_q;
		adr_wph_d  = adr_wph_q;
		pad_d      = pad_q;
		rsp        = '{src: SRC_REG, rdata: 8'h00, vram_valid: 1'b0,
			vram_addr: 16'h0000, vram_byte: 8'h00};
		macc       = '{rd: 1'b0, we: 1'b0, addr: a, wdata: req.wdata};
		spr_we     = 1'b0;
		spr_re     = 1'b0;
		unique case (req.cmd)
			CMD_READ: begin
				if (is_pad) begin
					rsp.rdata = {7'd0, pad_q[0]} | PAD_OPEN;
					if (!req.ghost)
						pad_d = pad_q >> 1;
				end else if (in_regs) begin
					unique case (off)
						OFF_CTRL:    rsp.rdata = ctrl_q;
						OFF_MASK:    rsp.rdata = mask_q;
						OFF_STATUS: begin
							rsp.rdata = status_q;
							if (!req.ghost)
								status_d = status_q & ~VBLANK_BIT;
						end
						OFF_OAMADDR: rsp.rdata = oam_addr_q;
						OFF_OAMDATA: begin
							rsp.src = SRC_SPRITE;
							spr_re  = req.fire;
						end
						OFF_SCROLL: begin
							rsp.rdata = scr_ph ? scroll_q[7:0] : scroll_q[15:8];
							if (!req.ghost)
								scr_rph_d = scr_ph;
						end
						OFF_ADDR: begin
							rsp.rdata = adr_ph ? vaddr_q[7:0] : vaddr_q[15:8];
							if (!req.ghost)
								adr_rph_d = adr_ph;
						end
						OFF_DATA:    rsp.rdata = vdata_q;
						default:     rsp.rdata = 8'h00;
					endcase
				end else begin
					rsp.src = SRC_MAIN;
					macc.rd = req.fire;
				end
			end
			CMD_WORD: begin
				// raw store read, no register decoding
				rsp.src = SRC_WORD;
				macc.rd = req.fire;
			end
			CMD_WRITE: begin
				if (is_pad) begin
					if (req.wdata[0])
						pad_d = req.buttons;
				end else if (in_regs) begin
					unique case (off)
						OFF_CTRL: begin
							if (req.cycles >= CTRL_WARMUP)
								ctrl_d = req.wdata;
						end
						OFF_MASK:    mask_d = req.wdata;
						OFF_STATUS:  status_d = req.wdata;
						OFF_OAMADDR: oam_addr_d = req.wdata;
						OFF_OAMDATA: spr_we = req.fire;
						OFF_SCROLL: begin
							scroll_d  = scr_wph_q ? {req.wdata, scroll_q[7:0]} :
								{scroll_q[15:8], req.wdata};
							scr_wph_d = ~scr_wph_q;
						end
						OFF_ADDR: begin
							vaddr_d   = adr_wph_q ? {req.wdata, vaddr_q[7:0]} :
								{vaddr_q[15:8], req.wdata};
							adr_wph_d = ~adr_wph_q;
						end
						OFF_DATA: begin
							vdata_d        = req.wdata;
							rsp.vram_valid = 1'b1;
							rsp.vram_addr  = vaddr_q;
							rsp.vram_byte  = req.wdata;
							vaddr_d        = (vaddr_q + stride) & VADDR_MASK;
						end
						default: ;
					endcase
				end else begin
					macc.we = req.fire;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
		end else if (cfg_we) begin
			mirror_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q     <= 8'h00;
			mask_q     <= 8'h00;
			status_q   <= 8'h00;
			oam_addr_q <= 8'h00;
			scroll_q   <= 16'h0000;
			vaddr_q    <= 16'h0000;
			vdata_q    <= 8'h00;
			scr_rph_q  <= 1'b1;
			scr_wph_q  <= 1'b1;
			adr_rph_q  <= 1'b1;
			adr_wph_q  <= 1'b1;
			pad_q      <= 8'h00;
		end else if (req.fire) begin
			ctrl_q     <= ctrl_d;
			mask_q     <= mask_d;
			status_q   <= status_d;
			oam_addr_q <= oam_addr_d;
			scroll_q   <= scroll_d;
			vaddr_q    <= vaddr_d;
			vdata_q    <= vdata_d;
			scr_rph_q  <= scr_rph_d;
			scr_wph_q  <= scr_wph_d;
			adr_rph_q  <= adr_rph_d;
			adr_wph_q  <= adr_wph_d;
			pad_q      <= pad_d;
		end
	end

	ccbrd_ram #(.WIDTH(8), .DEPTH(256)) u_sprite (
		.clk   (clk),
		.we    (spr_we),
		.waddr (oam_addr_q),
		.wdata (req.wdata),
		.re    (spr_re),
		.raddr (oam_addr_q),
		.rdata (spr_rdata)
	);
endmodule

[rtl/console_cpu_bus_register_decoder.sv]
// CPU bus register decoder. Throughput: one access per cycle (byte, word or write)
// while the result channel is ready; the input register feeds one decode stage, store
// reads land in the registered RAM outputs of the result stage.
// Reset: arst_n clears video registers, phases, pad shifter, mirror flag and valids
// at once; sprite and main store contents stay undefined, no clearing pass.
module console_cpu_bus_register_decoder
	import ccbrd_pkg::*;
#(
	parameter int ROM_BASE      = 32768,
	parameter int ROM_BANK_SIZE = 16384,
	parameter int PAD_PORT_ADDR = 16406
) (
	input  logic           clk,
	input  logic           arst_n,
	ccbrd_access_if.sink   access,
	ccbrd_result_if.source result,
	input  logic           cfg_we,
	input  logic           cfg_wdata
);
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;
	logic        ghost_s1;
	logic [7:0]  buttons_s1;
	logic [15:0] cycles_s1;

	logic        valid_s2;
	rsp_t        rsp_s2;

	logic        advance;
	logic        in_ready;
	req_t        req;
	rsp_t        rsp;
	macc_t       macc;
	logic [7:0]  spr_rdata;
	logic [7:0]  main_lo;
	logic [7:0]  main_hi;

	assign advance  = valid_s1 && (!valid_s2 || result.ready);
	assign in_ready = !valid_s1 || advance;
	assign access.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= access.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (access.valid && in_ready) begin
			cmd_s1     <= access.command;
			addr_s1    <= access.address;
			wdata_s1   <= access.write_data;
			ghost_s1   <= access.ghost;
			buttons_s1 <= access.button_state;
			cycles_s1  <= access.video_cycles;
		end
	end

	assign req = '{fire: advance, cmd: cmd_s1, addr: addr_s1, wdata: wdata_s1,
		ghost: ghost_s1, buttons: buttons_s1, cycles: cycles_s1};

	ccbrd_regs #(
		.ROM_BASE      (ROM_BASE),
		.ROM_BANK_SIZE (ROM_BANK_SIZE),
		.PAD_PORT_ADDR (PAD_PORT_ADDR)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.macc      (macc),
		.spr_rdata (spr_rdata)
	);

	ccbrd_mstore u_mstore (
		.clk (clk),
		.acc (macc),
		.lo  (main_lo),
		.hi  (main_hi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			rsp_s2 <= rsp;
	end

	// RAM outputs only move on advance, so they hold with the stalled beat
	always_comb begin
		unique case (rsp_s2.src)
			SRC_REG:    result.read_data = {8'h00, rsp_s2.rdata};
			SRC_SPRITE: result.read_data = {8'h00, spr_rdata};
			SRC_MAIN:   result.read_data = {8'h00, main_lo};
			SRC_WORD:   result.read_data = {main_hi, main_lo};
			default:    result.read_data = 16'h0000;
		endcase
	end

	assign result.valid              = valid_s2;
	assign result.vram_write_valid   = rsp_s2.vram_valid;
	assign result.vram_write_address = rsp_s2.vram_addr;
	assign result.vram_write_byte    = rsp_s2.vram_byte;
endmodule

[rtl/ccbrd_checker.sv]
// Port-level checks of the CPU bus register decoder, bound to the top level.
// Depends on console_cpu_bus_register_decoder (bind target).
module ccbrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        acc_valid,
	input logic        acc_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] res_read_data,
	input logic        res_vram_valid,
	input logic [15:0] res_vram_addr,
	input logic [7:0]  res_vram_byte
);
	logic [1:0] inflight_q;
	logic       acc_fire;
	logic       res_fire;

	assign acc_fire = acc_valid && acc_ready;
	assign res_fire = res_valid && res_ready;

	// beats taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 2'd0;
		end else begin
			inflight_q <= inflight_q + {1'b0, acc_fire} - {1'b0, res_fire};
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_read_data) &&
		$stable(res_vram_valid) && $stable(res_vram_addr) && $stable(res_vram_byte))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> inflight_q != 2'd0)
		else $error("result without an accepted access");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 2'd2)
		else $error("more beats in flight than pipeline stages");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 2'd0 |-> acc_ready)
		else $error("empty pipeline refuses an access");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 2'd2 && !res_ready |-> !acc_ready)
		else $error("full pipeline took an access while stalled");
endmodule

bind console_cpu_bus_register_decoder ccbrd_checker u_ccbrd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.acc_valid      (access.valid),
	.acc_ready      (access.ready),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_read_data  (result.read_data),
	.res_vram_valid (result.vram_write_valid),
	.res_vram_addr  (result.vram_write_address),
	.res_vram_byte  (result.vram_write_byte)
);

[tb/tb_console_cpu_bus_register_decoder.sv]
`timescale 1ns / 1ps
// Testbench for the CPU bus register decoder: directed register and store checks, then
// random bus traffic scored against an in-bench model. Depends on ccbrd_pkg, the decoder
// and the access and result channel interfaces.
module tb_console_cpu_bus_register_decoder;
	import ccbrd_pkg::*;

	localparam int ROM_BASE      = 32768;
	localparam int ROM_BANK_SIZE = 16384;
	localparam int PAD_PORT_ADDR = 16406;
	localparam int ROM_TOP       = ROM_BASE + ROM_BANK_SIZE;
	localparam logic [15:0] PAD_ADDR = 16'(PAD_PORT_ADDR);
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int SETTLE_CYCLES  = 4;
	localparam int MAX_PRINTED    = 40;

	typedef struct {
		logic [1:0]  command;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic        ghost;
		logic [7:0]  button_state;
		logic [15:0] video_cycles;
	} bus_access_t;

	typedef struct {
		logic [15:0] read_data;
		logic        vram_valid;
		logic [15:0] vram_addr;
		logic [7:0]  vram_byte;
	} bus_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	ccbrd_access_if access_ch();
	ccbrd_result_if result_ch();

	console_cpu_bus_register_decoder #(
		.ROM_BASE(ROM_BASE),
		.ROM_BANK_SIZE(ROM_BANK_SIZE),
		.PAD_PORT_ADDR(PAD_PORT_ADDR)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.access(access_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Model state of the decoder
	logic        mirror_on;
	logic [7:0]  ctrl_q, mask_q, status_q, oam_addr_q, vdata_q, pad_shift;
	logic [15:0] scroll_q, vaddr_q;
	logic        scroll_rd_ph, scroll_wr_ph, addr_rd_ph, addr_wr_ph;
	logic [7:0]  sprite_mem [0:255];
	bit          sprite_written [0:255];
	logic [7:0]  main_mem [0:65535];
	bit          main_written [0:65535];
	logic [15:0] written_addrs [$];

	bus_result_t expected_results [$];
	int mismatch_count;
	int result_beats;
	int idle_cycles;
	bit calm;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [15:0] fold_bus_addr(logic [15:0] a);
		if (a >= REG_FIRST && a <= REG_LAST)
			return REG_FIRST | (a & REG_FOLD);
		if (mirror_on && a >= ROM_TOP)
			return a - 16'(ROM_BANK_SIZE);
		return a;
	endfunction

	// Bus address that lands on store entry t, picking the upper alias at random when mirrored
	function automatic logic [15:0] rom_view_addr(logic [15:0] t);
		if (mirror_on && t >= ROM_BASE && t < ROM_TOP && $urandom_range(0, 1))
			return t + 16'(ROM_BANK_SIZE);
		return t;
	endfunction

	function automatic bit reads_unwritten(bus_access_t b);
		logic [15:0] t, tn;
		t = fold_bus_addr(b.address);
		tn = t + 16'd1;
		if (b.command == CMD_WORD)
			return !main_written[t] || !main_written[tn];
		if (b.command != CMD_READ || t == PAD_ADDR)
			return 1'b0;
		if (t[15:3] == REG_FIRST[15:3])
			return t[2:0] == OFF_OAMDATA && !sprite_written[oam_addr_q];
		return !main_written[t];
	endfunction

	function automatic bus_result_t predict_beat(bus_access_t b);
		bus_result_t r;
		logic [15:0] t, tn;
		logic [7:0] v;
		logic ph;
		r = '{read_data: 16'h0, vram_valid: 1'b0, vram_addr: 16'h0, vram_byte: 8'h0};
		t = fold_bus_addr(b.address);
		tn = t + 16'd1;
		v = 8'h00;
		if (b.command == CMD_WORD) begin
			r.read_data = {main_mem[tn], main_mem[t]};
		end else if (b.command == CMD_READ) begin
			if (t == PAD_ADDR) begin
				v = {7'b0, pad_shift[0]} | PAD_OPEN;
				if (!b.ghost)
					pad_shift = pad_shift >> 1;
			end else if (t[15:3] == REG_FIRST[15:3]) begin
				case (t[2:0])
					OFF_CTRL:    v = ctrl_q;
					OFF_MASK:    v = mask_q;
					OFF_STATUS: begin
						v = status_q;
						if (!b.ghost)
							status_q = status_q & ~VBLANK_BIT;
					end
					OFF_OAMADDR: v = oam_addr_q;
					OFF_OAMDATA: v = sprite_mem[oam_addr_q];
					OFF_SCROLL: begin
						ph = ~scroll_rd_ph;
						if (!b.ghost)
							scroll_rd_ph = ph;
						v = ph ? scroll_q[7:0] : scroll_q[15:8];
					end
					OFF_ADDR: begin
						ph = ~addr_rd_ph;
						if (!b.ghost)
							addr_rd_ph = ph;
						v = ph ? vaddr_q[7:0] : vaddr_q[15:8];
					end
					default:     v = vdata_q;
				endcase
			end else begin
				v = main_mem[t];
			end
			r.read_data = {8'h00, v};
		end else if (b.command == CMD_WRITE) begin
			if (t == PAD_ADDR) begin
				if (b.write_data[0])
					pad_shift = b.button_state;
			end else if (t[15:3] == REG_FIRST[15:3]) begin
				case (t[2:0])
					OFF_CTRL: begin
						if (b.video_cycles >= CTRL_WARMUP)
							ctrl_q = b.write_data;
					end
					OFF_MASK:    mask_q = b.write_data;
					OFF_STATUS:  status_q = b.write_data;
					OFF_OAMADDR: oam_addr_q = b.write_data;
					OFF_OAMDATA: begin
						sprite_mem[oam_addr_q] = b.write_data;
						sprite_written[oam_addr_q] = 1'b1;
					end
					OFF_SCROLL: begin
						if (scroll_wr_ph)
							scroll_q[15:8] = b.write_data;
						else
							scroll_q[7:0] = b.write_data;
						scroll_wr_ph = ~scroll_wr_ph;
					end
					OFF_ADDR: begin
						if (addr_wr_ph)
							vaddr_q[15:8] = b.write_data;
						else
							vaddr_q[7:0] = b.write_data;
						addr_wr_ph = ~addr_wr_ph;
					end
					default: begin
						vdata_q = b.write_data;
						r.vram_valid = 1'b1;
						r.vram_addr = vaddr_q;
						r.vram_byte = b.write_data;
						vaddr_q = (vaddr_q + (ctrl_q[CTRL_INC_BIT] ? STRIDE_ROW : STRIDE_ONE))
							& VADDR_MASK;
					end
				endcase
			end else begin
				main_mem[t] = b.write_data;
				if (!main_written[t]) begin
					main_written[t] = 1'b1;
					written_addrs.push_back(t);
				end
			end
		end
		return r;
	endfunction

	function automatic bus_access_t mk_access(logic [1:0] cmd, logic [15:0] addr,
		logic [7:0] wd, logic gh, logic [7:0] buttons, logic [15:0] cycles);
		bus_access_t b;
		b.command = cmd;
		b.address = addr;
		b.write_data = wd;
		b.ghost = gh;
		b.button_state = buttons;
		b.video_cycles = cycles;
		return b;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("mismatch at result beat %0d: %s got %h want %h", result_beats, what,
				got, want);
	endtask

	// One beat on the access channel; the model advances when it is taken
	task automatic send_access(bus_access_t b);
		@(negedge clk);
		access_ch.valid <= 1'b1;
		access_ch.command <= b.command;
		access_ch.address <= b.address;
		access_ch.write_data <= b.write_data;
		access_ch.ghost <= b.ghost;
		access_ch.button_state <= b.button_state;
		access_ch.video_cycles <= b.video_cycles;
		do @(posedge clk); while (!access_ch.ready);
		expected_results.push_back(predict_beat(b));
	endtask

	task automatic issue(bus_access_t b);
		int gap;
		send_access(b);
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			access_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		access_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_mirror(logic v);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		mirror_on = v;
	endtask

	task automatic test_control_warmup();
		issue(mk_access(CMD_WRITE, 16'h2000, 8'hFF, 1'b0, 8'h00, CTRL_WARMUP - 16'd1));
		issue(mk_access(CMD_READ, 16'h2000, 8'h00, 1'b0, 8'h00, 16'h0000));
		issue(mk_access(CMD_WRITE, 16'h3FF8, 8'h7B, 1'b1, 8'h00, CTRL_WARMUP));
		issue(mk_access(CMD_READ, 16'h2008, 8'h00, 1'b0, 8'h00, 16'hFFFF));
	endtask

	task automatic test_status_vblank();
		issue(mk_access(CMD_WRITE, 16'h2002, 8'hFF, 1'b0, 8'h00, 16'h0000));
		issue(mk_access(CMD_READ, 16'h2002, 8'h00, 1'b1, 8'h00, 16'h0000));
		issue(mk_access(CMD_READ, 16'h3FFA, 8'h00, 1'b0, 8'h00, 16'h0000));
	endtask

	task automatic test_sprite_port();
		issue(mk_access(CMD_WRITE, 16'h3FFB, 8'hFF, 1'b0, 8'h00, 16'h0000));
		issue(mk_access(CMD_WRITE, 16'h2004, 8'h00, 1'b0, 8'h00, 16'h0000));
		issue(mk_access(CMD_READ, 16'h2004, 8'h00, 1'b1, 8'h00, 16'h0000));
	endtask

	task automatic test_scroll_phases();
		issue(mk_access(CMD_WRITE, 16'h2005, 8'h12, 1'b0, 8'h00, 16'h0000));
		issue(mk_access(CMD_WRITE, 16'h2005, 8'h34, 1'b0, 8'h00, 16'h0000));
		issue(mk_access(CMD_READ, 16'h2005, 8'h00, 1'b0, 8'h00, 16'h0000));
	endtask

	task automatic test_video_addr_data();
		issue(mk_access(CMD_WRITE, 16'h2006, 8'hFF, 1'b0, 8'h00, 16'h0000));
		issue(mk_access(CMD_WRITE, 16'h2006, 8'hFF, 1'b0, 8'h00, 16'h0000));
		// data write at 0xFFFF: the address wraps to zero in 14 bits
		issue(mk_access(CMD_WRITE, 16'h3FFF, 8'hAA, 1'b0, 8'h00, 16'h0000));
		issue(mk_access(CMD_READ, 16'h2006, 8'h00, 1'b0, 8'h00, 16'h0000));
	endtask

	task automatic test_pad_port();
		issue(mk_access(CMD_WRITE, PAD_ADDR, 8'h01, 1'b0, 8'h81, 16'h0000));
		issue(mk_access(CMD_READ, PAD_ADDR, 8'h00, 1'b0, 8'h00, 16'h0000));
		issue(mk_access(CMD_READ, PAD_ADDR, 8'h00, 1'b1, 8'h00, 16'h0000));
	endtask

	task automatic test_main_store_word();
		issue(mk_access(CMD_WRITE, 16'hFFFF, 8'h00, 1'b1, 8'hFF, 16'hFFFF));
		issue(mk_access(CMD_WRITE, 16'h0000, 8'hFF, 1'b0, 8'h00, 16'h0000));
		// word read across the top of the address space
		issue(mk_access(CMD_WORD, 16'hFFFF, 8'h00, 1'b1, 8'h00, 16'h0000));
	endtask

	task automatic test_unused_command();
		issue(mk_access(CMD_UNUSED, 16'h2007, 8'hFF, 1'b1, 8'hFF, 16'hFFFF));
	endtask

	task automatic test_rom_mirror();
		set_mirror(1'b1);
		issue(mk_access(CMD_WRITE, 16'hFFFF, 8'hC3, 1'b0, 8'h00, 16'h0000));
		issue(mk_access(CMD_READ, 16'hBFFF, 8'h00, 1'b0, 8'h00, 16'h0000));
		issue(mk_access(CMD_READ, 16'hFFFF, 8'h00, 1'b1, 8'h00, 16'h0000));
	endtask

	task automatic test_random_traffic(int count);
		bus_access_t b, w;
		logic [15:0] t, tn;
		int sel;
		for (int i = 0; i < count; i++) begin
			b = mk_access(CMD_WRITE, 16'($urandom), 8'($urandom), 1'($urandom),
				8'($urandom), 16'($urandom));
			sel = $urandom_range(0, 99);
			if (sel >= 25 && sel < 55 && written_addrs.size() > 0) begin
				t = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
				if (sel >= 45) begin
					// word read: make sure the upper byte exists first
					tn = t + 16'd1;
					if (!main_written[tn] && fold_bus_addr(tn) == tn) begin
						w = b;
						w.address = tn;
						issue(w);
					end
					b.command = CMD_WORD;
				end else begin
					b.command = CMD_READ;
				end
				b.address = rom_view_addr(t);
			end else if (sel >= 55 && sel < 85) begin
				b.address = {3'b001, 13'($urandom)};
				b.command = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
			end else if (sel >= 85 && sel < 93) begin
				b.address = PAD_ADDR;
				b.command = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
			end else if (sel >= 93 && sel < 95) begin
				b.command = CMD_UNUSED;
			end else if (sel >= 95) begin
				b.command = 2'($urandom_range(0, 2));
			end
			if (reads_unwritten(b))
				b.command = CMD_WRITE;
			issue(b);
		end
	endtask

	// Result side backpressure
	initial begin
		int stall, burst;
		result_ch.ready = 1'b0;
		forever begin
			stall = calm ? 0 : pick_gap();
			if (stall > 0) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			burst = $urandom_range(1, 12);
			@(negedge clk);
			result_ch.ready <= 1'b1;
			repeat (burst - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin : score_results
		bus_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			result_beats++;
			if (expected_results.size() == 0) begin
				report_mismatch("beat with nothing pending, read_data", result_ch.read_data,
					16'h0);
			end else begin
				want = expected_results.pop_front();
				if (result_ch.read_data !== want.read_data)
					report_mismatch("read_data", result_ch.read_data, want.read_data);
				if (result_ch.vram_write_valid !== want.vram_valid)
					report_mismatch("vram_write_valid", 16'(result_ch.vram_write_valid),
						16'(want.vram_valid));
				if (result_ch.vram_write_address !== want.vram_addr)
					report_mismatch("vram_write_address", result_ch.vram_write_address,
						want.vram_addr);
				if (result_ch.vram_write_byte !== want.vram_byte)
					report_mismatch("vram_write_byte", 16'(result_ch.vram_write_byte),
						16'(want.vram_byte));
			end
		end
	end

	always @(posedge clk) begin
		if ((access_ch.valid && access_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		access_ch.valid = 1'b0;
		access_ch.command = CMD_READ;
		access_ch.address = 16'h0;
		access_ch.write_data = 8'h0;
		access_ch.ghost = 1'b0;
		access_ch.button_state = 8'h0;
		access_ch.video_cycles = 16'h0;
		mismatch_count = 0;
		result_beats = 0;
		idle_cycles = 0;
		calm = 1'b0;
		mirror_on = 1'b0;
		ctrl_q = 8'h0;
		mask_q = 8'h0;
		status_q = 8'h0;
		oam_addr_q = 8'h0;
		vdata_q = 8'h0;
		pad_shift = 8'h0;
		scroll_q = 16'h0;
		vaddr_q = 16'h0;
		scroll_rd_ph = 1'b1;
		scroll_wr_ph = 1'b1;
		addr_rd_ph = 1'b1;
		addr_wr_ph = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_mirror(1'b0);
		test_control_warmup();
		test_status_vblank();
		test_sprite_port();
		test_scroll_phases();
		test_video_addr_data();
		test_pad_port();
		test_main_store_word();
		test_unused_command();
		test_rom_mirror();

		test_random_traffic(350);
		set_mirror(1'b0);
		test_random_traffic(175);
		drain_results();
		test_random_traffic(175);
		calm = 1'b1;
		test_random_traffic(300);
		calm = 1'b0;
		set_mirror(1'b1);
		test_random_traffic(300);

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
